>>> rtl/core/mexp_pkg.sv
// Shared constants and control/status types for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

  // Default operand width in bits.
  localparam int unsigned DATA_WIDTH_DEF = 63;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new item
    logic start_base;  // begin reducing the base modulo the modulus
    logic start_mul;   // begin acc * sq
    logic start_sq;    // begin sq * sq
    logic step;        // one shift-and-add step of the product unit
    logic wr_sq;       // store product into the running square
    logic wr_acc;      // store product into the accumulator
    logic shift_e;     // drop the lowest exponent bit
    logic res_ld;      // load the output register
  } mexp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_zero;   // modulus is zero
    logic e_zero;   // remaining exponent is zero
    logic e_lsb;    // lowest remaining exponent bit
    logic my_zero;  // product multiplier fully consumed
  } mexp_sts_t;

endpackage : mexp_pkg

`default_nettype wire

>>> rtl/core/mexp_dp.sv
// Datapath: operand registers and the shared shift-and-add modular product unit.
`default_nettype none

module mexp_dp
  import mexp_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire mexp_cmd_t             cmd,
  input  wire logic [DATA_WIDTH-1:0] in_base,
  input  wire logic [DATA_WIDTH-1:0] in_exponent,
  input  wire logic [DATA_WIDTH-1:0] in_modulus,
  output mexp_sts_t                  sts,
  output logic      [DATA_WIDTH-1:0] result
);

  logic [DATA_WIDTH-1:0] m_r,   m_nxt;
  logic [DATA_WIDTH-1:0] e_r,   e_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] sq_r,  sq_nxt;
  logic [DATA_WIDTH-1:0] ma_r,  ma_nxt;   // product partial sum
  logic [DATA_WIDTH-1:0] md_r,  md_nxt;   // product addend, doubled each step
  logic [DATA_WIDTH-1:0] my_r,  my_nxt;   // product multiplier, shifted right
  logic [DATA_WIDTH-1:0] res_r, res_nxt;

  logic [DATA_WIDTH:0]   sum_w;
  logic [DATA_WIDTH:0]   dbl_w;
  logic [DATA_WIDTH:0]   mod_w;
  logic [DATA_WIDTH-1:0] sum_red;
  logic [DATA_WIDTH-1:0] dbl_red;
  logic                  in_m_nz;
  logic                  in_m_one;

  // Both operands stay below the modulus, so one conditional subtract reduces each.
  assign mod_w   = {1'b0, m_r};
  assign sum_w   = {1'b0, ma_r} + {1'b0, md_r};
  assign dbl_w   = {md_r, 1'b0};
  assign sum_red = (sum_w >= mod_w) ? DATA_WIDTH'(sum_w - mod_w) : sum_w[DATA_WIDTH-1:0];
  assign dbl_red = (dbl_w >= mod_w) ? DATA_WIDTH'(dbl_w - mod_w) : dbl_w[DATA_WIDTH-1:0];

  assign in_m_nz  = (in_modulus != '0);
  assign in_m_one = (in_modulus == DATA_WIDTH'(1));

  // Next-value selection under the controller's commands.
  always_comb begin
    m_nxt   = m_r;
    e_nxt   = e_r;
    acc_nxt = acc_r;
    sq_nxt  = sq_r;
    ma_nxt  = ma_r;
    md_nxt  = md_r;
    my_nxt  = my_r;
    res_nxt = res_r;

    // The accumulator starts at 0 for a zero modulus, 1 for a zero exponent,
    // and otherwise at 1 reduced modulo the modulus. The base waits in sq.
    if (cmd.load) begin
      m_nxt   = in_modulus;
      e_nxt   = in_exponent;
      sq_nxt  = in_base;
      acc_nxt = (in_m_nz && (in_exponent == '0 || !in_m_one)) ? DATA_WIDTH'(1) : '0;
    end

    // The base is reduced as (1 mod m) times the base.
    if (cmd.start_base) begin
      ma_nxt = '0;
      md_nxt = (m_r == DATA_WIDTH'(1)) ? '0 : DATA_WIDTH'(1);
      my_nxt = sq_r;
    end

    if (cmd.start_mul) begin
      ma_nxt = '0;
      md_nxt = acc_r;
      my_nxt = sq_r;
    end

    if (cmd.start_sq) begin
      ma_nxt = '0;
      md_nxt = sq_r;
      my_nxt = sq_r;
    end

    if (cmd.step) begin
      if (my_r[0]) begin
        ma_nxt = sum_red;
      end
      md_nxt = dbl_red;
      my_nxt = my_r >> 1;
    end

    if (cmd.wr_sq) begin
      sq_nxt = ma_r;
    end
    if (cmd.wr_acc) begin
      acc_nxt = ma_r;
    end
    if (cmd.shift_e) begin
      e_nxt = e_r >> 1;
    end
    if (cmd.res_ld) begin
      res_nxt = acc_r;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    e_r   <= e_nxt;
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    ma_r  <= ma_nxt;
    md_r  <= md_nxt;
    my_r  <= my_nxt;
    res_r <= res_nxt;
  end

  assign sts.m_zero  = (m_r == '0);
  assign sts.e_zero  = (e_r == '0);
  assign sts.e_lsb   = e_r[0];
  assign sts.my_zero = (my_r == '0);
  assign result      = res_r;

endmodule : mexp_dp

`default_nettype wire

>>> rtl/core/mexp_ctrl.sv
// Controller: sequences base reduction, multiplies and squarings, and the output handshake.
`default_nettype none

module mexp_ctrl
  import mexp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  input  wire mexp_sts_t sts,
  output mexp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_BASE,
    S_BIT,
    S_MUL,
    S_SQ,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Commands and next state.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.m_zero || sts.e_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.start_base = 1'b1;
          state_nxt      = S_BASE;
        end
      end
      S_BASE: begin
        if (sts.my_zero) begin
          cmd.wr_sq = 1'b1;
          state_nxt = S_BIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_BIT: begin
        if (sts.e_zero) begin
          state_nxt = S_FIN;
        end else if (sts.e_lsb) begin
          cmd.start_mul = 1'b1;
          state_nxt     = S_MUL;
        end else begin
          cmd.start_sq = 1'b1;
          state_nxt    = S_SQ;
        end
      end
      S_MUL: begin
        if (sts.my_zero) begin
          cmd.wr_acc   = 1'b1;
          cmd.start_sq = 1'b1;
          state_nxt    = S_SQ;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SQ: begin
        if (sts.my_zero) begin
          cmd.wr_sq   = 1'b1;
          cmd.shift_e = 1'b1;
          state_nxt   = S_BIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FIN: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_r || out_tready) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.res_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule : mexp_ctrl

`default_nettype wire

>>> rtl/core/modular_exponentiation.sv
// Top level: base^exponent mod modulus by right-to-left square-and-multiply.
// When the modulus or exponent is zero the result is loaded without any products; otherwise
// the work is set by one shift-and-add step per cycle on the shared product unit, each
// product taking one step per multiplier bit.
// One item is in work at a time; the next is accepted once the result is in the output register.
// Reset (rst_n, synchronous, active low) returns the controller to idle and drops out_tvalid.
`default_nettype none

module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned IN_W      = ((3 * DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // base, exponent, modulus, zero pad
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [OUT_W-1:0] out_tdata   // result, zero pad
);

  mexp_cmd_t             cmd;
  mexp_sts_t             sts;
  logic [DATA_WIDTH-1:0] result;

  mexp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mexp_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .in_base     (in_tdata[DATA_WIDTH-1:0]),
    .in_exponent (in_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .in_modulus  (in_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
    .sts         (sts),
    .result      (result)
  );

  assign out_tdata = OUT_W'(result);

  // An accepted item closes the input until its result is out.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in work");

  // A fresh result appears only at the end of an item's work.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised without an item in work");

  // The output register is loaded only at the end of the sequence.
  a_res_ld_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |=> (in_tready && out_tvalid))
    else $error("result load did not return the block to idle");

endmodule : modular_exponentiation

`default_nettype wire
